// ----- hdl/sats_pkg.sv -----
// Shared types and constants for the trimmed-sum converter sampler.
// No dependencies; imported by sats_ctrl, sats_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sats_pkg;

    localparam int SUM_W      = 25;
    localparam int COUNT_W    = 8;
    localparam int LIMIT_W    = 16;
    localparam int BIT_IDX_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CMD_BITS   = 16;

    localparam logic [CMD_BITS-1:0]  READ_CMD          = 16'hD000;
    localparam logic [COUNT_W-1:0]   SAMPLE_COUNT_RST  = 8'd8;
    localparam logic [LIMIT_W-1:0]   TIMEOUT_LIMIT_RST = 16'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd1;

    typedef struct packed {
        logic step;
        logic start_run;
        logic wait_tick;
        logic read_tick;
        logic busy;
        logic done;
        logic ok;
    } cmd_t;

    typedef struct packed {
        logic wait_expire;
        logic word_last;
        logic run_last;
    } sts_t;

endpackage

`default_nettype wire

// ----- hdl/sats_dp.sv -----
// Datapath: config registers, counters, shift register, sum/min/max, output registers.
// Depends on sats_pkg; driven by commands from sats_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sats_dp #(
    parameter int WORD_BITS = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [sats_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [sats_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  sats_pkg::cmd_t                   cmd,
    output sats_pkg::sts_t                   sts,
    input  wire                              eoc_level,
    input  wire                              dout_level,
    output logic                             convst_n,
    output logic                             chip_sel_n,
    output logic                             clock_pulse,
    output logic                             data_out,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             ok,
    output logic [sats_pkg::SUM_W-1:0]       result
);
    import sats_pkg::*;

    logic [COUNT_W-1:0]   sample_count_reg;
    logic [LIMIT_W-1:0]   timeout_limit_reg;

    logic [SUM_W-1:0]     running_sum_reg, running_sum_next;
    logic [WORD_BITS-1:0] largest_reg, largest_next;
    logic [WORD_BITS-1:0] smallest_reg, smallest_next;
    logic [WORD_BITS-1:0] shift_word_reg, shift_word_next;
    logic [BIT_IDX_W-1:0] bit_index_reg, bit_index_next;
    logic [COUNT_W-1:0]   sample_index_reg, sample_index_next;
    logic [LIMIT_W-1:0]   wait_count_reg, wait_count_next;
    logic [SUM_W-1:0]     result_reg, result_next;

    logic                 convst_n_reg, chip_sel_n_reg, clock_pulse_reg, data_out_reg;
    logic                 busy_reg, done_reg, ok_reg;

    logic [LIMIT_W-1:0]   wait_inc;
    logic [BIT_IDX_W-1:0] bit_inc;
    logic [COUNT_W-1:0]   sample_inc;
    logic [COUNT_W:0]     total_raw;
    logic [COUNT_W-1:0]   total;
    logic [WORD_BITS-1:0] word_new;
    logic [WORD_BITS-1:0] largest_upd, smallest_upd;
    logic [SUM_W-1:0]     sum_upd;
    logic                 cmd_bit;

    always_comb
    begin
        wait_inc   = wait_count_reg + 1'b1;
        bit_inc    = bit_index_reg + 1'b1;
        sample_inc = sample_index_reg + 1'b1;
        total_raw  = {1'b0, sample_count_reg} + (COUNT_W+1)'(2);
        total      = total_raw[COUNT_W] ? {COUNT_W{1'b1}} : total_raw[COUNT_W-1:0];

        sts.wait_expire = (wait_inc >= timeout_limit_reg);
        sts.word_last   = (bit_inc >= BIT_IDX_W'(WORD_BITS));
        sts.run_last    = (sample_inc >= total);

        word_new     = {shift_word_reg[WORD_BITS-2:0], dout_level};
        largest_upd  = (word_new > largest_reg) ? word_new : largest_reg;
        smallest_upd = (word_new < smallest_reg) ? word_new : smallest_reg;
        sum_upd      = running_sum_reg + SUM_W'(word_new);
        cmd_bit      = (bit_index_reg < BIT_IDX_W'(CMD_BITS)) ?
                       READ_CMD[~bit_index_reg[3:0]] : 1'b0;
    end

    always_comb
    begin
        running_sum_next  = running_sum_reg;
        largest_next      = largest_reg;
        smallest_next     = smallest_reg;
        shift_word_next   = shift_word_reg;
        bit_index_next    = bit_index_reg;
        sample_index_next = sample_index_reg;
        wait_count_next   = wait_count_reg;
        result_next       = result_reg;

        if (cmd.start_run)
        begin
            running_sum_next  = '0;
            largest_next      = '0;
            smallest_next     = '1;
            sample_index_next = '0;
            wait_count_next   = '0;
        end
        else if (cmd.wait_tick)
        begin
            wait_count_next = wait_inc;
            if (!sts.wait_expire && eoc_level)
            begin
                shift_word_next = '0;
                bit_index_next  = '0;
            end
        end
        else if (cmd.read_tick)
        begin
            shift_word_next = word_new;
            bit_index_next  = bit_inc;
            if (sts.word_last)
            begin
                largest_next      = largest_upd;
                smallest_next     = smallest_upd;
                running_sum_next  = sum_upd;
                sample_index_next = sample_inc;
                bit_index_next    = '0;
                if (sts.run_last)
                    result_next = sum_upd - SUM_W'(largest_upd) - SUM_W'(smallest_upd);
                else
                    wait_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg  <= SAMPLE_COUNT_RST;
            timeout_limit_reg <= TIMEOUT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SAMPLE_COUNT)
                sample_count_reg <= cfg_data[COUNT_W-1:0];
            else if (cfg_index == CFG_TIMEOUT_LIMIT)
                timeout_limit_reg <= cfg_data[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg  <= '0;
            largest_reg      <= '0;
            smallest_reg     <= '1;
            shift_word_reg   <= '0;
            bit_index_reg    <= '0;
            sample_index_reg <= '0;
            wait_count_reg   <= '0;
            result_reg       <= '0;
            convst_n_reg     <= 1'b1;
            chip_sel_n_reg   <= 1'b1;
            clock_pulse_reg  <= 1'b0;
            data_out_reg     <= 1'b1;
            busy_reg         <= 1'b0;
            done_reg         <= 1'b0;
            ok_reg           <= 1'b0;
        end
        else if (cmd.step)
        begin
            running_sum_reg  <= running_sum_next;
            largest_reg      <= largest_next;
            smallest_reg     <= smallest_next;
            shift_word_reg   <= shift_word_next;
            bit_index_reg    <= bit_index_next;
            sample_index_reg <= sample_index_next;
            wait_count_reg   <= wait_count_next;
            result_reg       <= result_next;
            convst_n_reg     <= !cmd.wait_tick;
            chip_sel_n_reg   <= !cmd.read_tick;
            clock_pulse_reg  <= cmd.wait_tick || cmd.read_tick;
            data_out_reg     <= cmd.read_tick ? cmd_bit : 1'b1;
            busy_reg         <= cmd.busy;
            done_reg         <= cmd.done;
            ok_reg           <= cmd.ok;
        end
    end

    assign convst_n    = convst_n_reg;
    assign chip_sel_n  = chip_sel_n_reg;
    assign clock_pulse = clock_pulse_reg;
    assign data_out    = data_out_reg;
    assign busy_res    = busy_reg;
    assign done_res    = done_reg;
    assign ok          = ok_reg;
    assign result      = result_reg;

endmodule

`default_nettype wire

// ----- hdl/sats_ctrl.sv -----
// Controller: run phase state machine and input/output beat handshake.
// Depends on sats_pkg; steers sats_dp through cmd_t, reads back sts_t.
`timescale 1ns / 1ps
`default_nettype none

module sats_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire             out_ready,
    input  wire             start_req,
    input  wire             eoc_level,
    input  sats_pkg::sts_t  sts,
    output sats_pkg::cmd_t  cmd
);
    import sats_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_READ
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next    = phase_reg;
        cmd           = '0;
        cmd.step      = accept;
        cmd.start_run = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    cmd.start_run = accept;
                    phase_next    = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                cmd.wait_tick = 1'b1;
                if (sts.wait_expire)
                begin
                    cmd.done   = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (eoc_level)
                    phase_next = PH_READ;
            end
            PH_READ:
            begin
                cmd.read_tick = 1'b1;
                if (sts.word_last)
                begin
                    if (sts.run_last)
                    begin
                        cmd.done   = 1'b1;
                        cmd.ok     = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                        phase_next = PH_WAIT;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        cmd.busy = (phase_next != PH_IDLE);

        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/spi_adc_trimmed_sum_sampler_unit.sv -----
// Top level of the trimmed-sum serial converter sampler.
// Depends on sats_pkg, sats_ctrl and sats_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one tick of pin levels per beat:
//   start_req, eoc_level, dout_level. Every input beat yields exactly one
//   output beat (out_valid/out_ready) with the pin drive levels, busy/done/ok
//   flags and the held trimmed sum (sum of all words minus largest and
//   smallest).
//   The output beat for an input is registered at the edge that accepts it.
//   Throughput is one beat per cycle while the receiver keeps out_ready high;
//   the whole tick is evaluated combinationally by the phase state machine and
//   the sum/min/max datapath.
//   The output register frees the input side: a new beat is taken whenever
//   the output register is empty or being drained in the same cycle. If the
//   receiver stalls, in_ready drops and the pending output beat holds.
//   Configuration: cfg_index 0 writes sample_count, 1 writes timeout_limit;
//   cfg_ready is always high. Write only while no run is in progress.
//   Reset: asynchronous, active low; returns to idle with sample_count 8,
//   timeout_limit 10000 and a held result of zero. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module spi_adc_trimmed_sum_sampler_unit #(
    parameter int WORD_BITS = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [sats_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [sats_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              start_req,
    input  wire                              eoc_level,
    input  wire                              dout_level,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic                             convst_n,
    output logic                             chip_sel_n,
    output logic                             clock_pulse,
    output logic                             data_out,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             ok,
    output logic [sats_pkg::SUM_W-1:0]       result
);
    import sats_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    sats_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .start_req (start_req),
        .eoc_level (eoc_level),
        .sts       (sts),
        .cmd       (cmd)
    );

    sats_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .eoc_level   (eoc_level),
        .dout_level  (dout_level),
        .convst_n    (convst_n),
        .chip_sel_n  (chip_sel_n),
        .clock_pulse (clock_pulse),
        .data_out    (data_out),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .ok          (ok),
        .result      (result)
    );

endmodule

`default_nettype wire

// ----- dv/tb_spi_adc_trimmed_sum_sampler_unit.sv -----
// Self-checking testbench for spi_adc_trimmed_sum_sampler_unit: directed pin ticks, then
// random measurement runs with random handshake stalls, checked against an in-bench predictor.
// Depends on sats_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_spi_adc_trimmed_sum_sampler_unit;

    import sats_pkg::*;

    localparam int WORD_BITS = 16;

    typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_READ} run_phase_e;
    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic             convst_n;
        logic             chip_sel_n;
        logic             clock_pulse;
        logic             data_out;
        logic             busy;
        logic             done;
        logic             ok;
        logic [SUM_W-1:0] result;
    } pin_beat_t;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [4:0]            reps;
        logic                  start;
        logic                  eoc;
        logic                  dout;
        logic                  typed;
        pin_beat_t             want;
    } step_row_t;

    localparam pin_beat_t IDLE_BEAT = '{convst_n: 1'b1, chip_sel_n: 1'b1, clock_pulse: 1'b0,
                                        data_out: 1'b1, busy: 1'b0, done: 1'b0, ok: 1'b0,
                                        result: '0};
    localparam pin_beat_t BUSY_BEAT = '{convst_n: 1'b1, chip_sel_n: 1'b1, clock_pulse: 1'b0,
                                        data_out: 1'b1, busy: 1'b1, done: 1'b0, ok: 1'b0,
                                        result: '0};
    localparam pin_beat_t ABORT_BEAT = '{convst_n: 1'b0, chip_sel_n: 1'b1, clock_pulse: 1'b1,
                                         data_out: 1'b1, busy: 1'b0, done: 1'b1, ok: 1'b0,
                                         result: '0};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  start_req = 1'b0;
    logic                  eoc_level = 1'b0;
    logic                  dout_level = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  convst_n;
    logic                  chip_sel_n;
    logic                  clock_pulse;
    logic                  data_out;
    logic                  busy_res;
    logic                  done_res;
    logic                  ok;
    logic [SUM_W-1:0]      result;

    // predicted sampler state and registers
    run_phase_e            ph_q = PH_IDLE;
    logic [SUM_W-1:0]      acc_sum = '0;
    logic [WORD_BITS-1:0]  top_word = '0;
    logic [WORD_BITS-1:0]  low_word = '1;
    logic [WORD_BITS-1:0]  shreg = '0;
    logic [4:0]            bit_pos = '0;
    logic [7:0]            words_done = '0;
    logic [15:0]           eoc_waits = '0;
    logic [SUM_W-1:0]      kept_sum = '0;
    logic [COUNT_W-1:0]    cnt_cfg = SAMPLE_COUNT_RST;
    logic [LIMIT_W-1:0]    limit_cfg = TIMEOUT_LIMIT_RST;

    pin_beat_t             due_beats[$];
    int                    mismatches = 0;
    int                    beats_seen = 0;
    int                    live_ticks = 0;
    int                    stall_req = 0;
    bit                    burst = 1'b0;
    bit                    in_live = 1'b0;
    bit                    cfg_live = 1'b0;

    step_row_t directed_rows [15] = '{
        '{ROW_CFG,  CFG_TIMEOUT_LIMIT, 16'd0, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, IDLE_BEAT},
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b1, IDLE_BEAT},
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd1,  1'b0, 1'b1, 1'b1, 1'b1, IDLE_BEAT},
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd1,  1'b1, 1'b0, 1'b0, 1'b1, BUSY_BEAT},
        // zero timeout: first wait tick aborts, eoc and restart ignored
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd1,  1'b1, 1'b1, 1'b1, 1'b1, ABORT_BEAT},
        '{ROW_CFG,  CFG_TIMEOUT_LIMIT, 16'd2, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, IDLE_BEAT},
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd1,  1'b1, 1'b0, 1'b1, 1'b1, BUSY_BEAT},
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd1,  1'b1, 1'b0, 1'b0, 1'b0, IDLE_BEAT},
        // limit reached on the same tick eoc rises: abort wins
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd1,  1'b0, 1'b1, 1'b0, 1'b1, ABORT_BEAT},
        '{ROW_CFG,  CFG_SAMPLE_COUNT,  16'd253, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, IDLE_BEAT},
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd1,  1'b1, 1'b0, 1'b0, 1'b1, BUSY_BEAT},
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd1,  1'b0, 1'b1, 1'b0, 1'b0, IDLE_BEAT},
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd16, 1'b0, 1'b0, 1'b1, 1'b0, IDLE_BEAT},
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0, IDLE_BEAT},
        '{ROW_TICK, CFG_SAMPLE_COUNT,  16'd0, 5'd1,  1'b1, 1'b1, 1'b0, 1'b1, ABORT_BEAT}
    };

    spi_adc_trimmed_sum_sampler_unit #(
        .WORD_BITS(WORD_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .start_req(start_req),
        .eoc_level(eoc_level),
        .dout_level(dout_level),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .convst_n(convst_n),
        .chip_sel_n(chip_sel_n),
        .clock_pulse(clock_pulse),
        .data_out(data_out),
        .busy_res(busy_res),
        .done_res(done_res),
        .ok(ok),
        .result(result)
    );

    always #5 clk = ~clk;

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_pin(input string name, input logic [SUM_W-1:0] got,
                             input logic [SUM_W-1:0] want);
        if (got !== want)
            log_mismatch($sformatf("beat %0d %s got %0h want %0h", beats_seen, name, got, want));
    endtask

    // one pin tick through the trimmed-sum sampler
    task automatic advance_sampler(input logic s, input logic e, input logic d,
                                   output pin_beat_t beat);
        logic [8:0] convs;
        convs = {1'b0, cnt_cfg} + 9'd2;
        if (convs > 9'd255)
            convs = 9'd255;
        beat = IDLE_BEAT;
        case (ph_q)
            PH_IDLE:
            begin
                if (s)
                begin
                    acc_sum = '0;
                    top_word = '0;
                    low_word = '1;
                    words_done = '0;
                    eoc_waits = '0;
                    ph_q = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                beat.convst_n = 1'b0;
                beat.clock_pulse = 1'b1;
                eoc_waits = eoc_waits + 16'd1;
                if (eoc_waits >= limit_cfg)
                begin
                    beat.done = 1'b1;
                    ph_q = PH_IDLE;
                end
                else if (e)
                begin
                    shreg = '0;
                    bit_pos = '0;
                    ph_q = PH_READ;
                end
            end
            PH_READ:
            begin
                beat.chip_sel_n = 1'b0;
                beat.clock_pulse = 1'b1;
                beat.data_out = (bit_pos < CMD_BITS) ? READ_CMD[CMD_BITS - 1 - bit_pos] : 1'b0;
                shreg = {shreg[WORD_BITS-2:0], d};
                bit_pos = bit_pos + 5'd1;
                if (bit_pos >= WORD_BITS)
                begin
                    if (shreg > top_word)
                        top_word = shreg;
                    if (shreg < low_word)
                        low_word = shreg;
                    acc_sum = acc_sum + SUM_W'(shreg);
                    words_done = words_done + 8'd1;
                    bit_pos = '0;
                    if ({1'b0, words_done} >= convs)
                    begin
                        kept_sum = acc_sum - SUM_W'(top_word) - SUM_W'(low_word);
                        beat.done = 1'b1;
                        beat.ok = 1'b1;
                        ph_q = PH_IDLE;
                    end
                    else
                    begin
                        eoc_waits = '0;
                        ph_q = PH_WAIT;
                    end
                end
            end
            default:
                ph_q = PH_IDLE;
        endcase
        beat.busy = (ph_q != PH_IDLE);
        beat.result = kept_sum;
    endtask

    task automatic offer_tick(input logic s, input logic e, input logic d, input logic typed,
                              input pin_beat_t want);
        pin_beat_t beat;
        int gap;
        if (cfg_live)
        begin
            cfg_valid <= 1'b0;
            cfg_live = 1'b0;
        end
        if (ph_q != PH_IDLE || s)
            live_ticks++;
        advance_sampler(s, e, d, beat);
        if (typed)
            beat = want;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            if (in_live)
            begin
                in_valid <= 1'b0;
                in_live = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_live = 1'b1;
        start_req <= s;
        eoc_level <= e;
        dout_level <= d;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        due_beats.push_back(beat);
        @(posedge clk);
    endtask

    // register writes only once the sampler is idle and drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        if (in_live)
        begin
            in_valid <= 1'b0;
            in_live = 1'b0;
        end
        while (due_beats.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_live = 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        if (idx == CFG_SAMPLE_COUNT)
            cnt_cfg = val[COUNT_W-1:0];
        else if (idx == CFG_TIMEOUT_LIMIT)
            limit_cfg = val[LIMIT_W-1:0];
    endtask

    // idle noise, then a start and a well-formed conversion sequence with random content
    task automatic measure_run();
        logic [WORD_BITS-1:0] word;
        int idle_n;
        word = '0;
        idle_n = $urandom_range(0, 2);
        repeat (idle_n) offer_tick(1'b0, coin(), coin(), 1'b0, IDLE_BEAT);
        if (ph_q == PH_IDLE)
            offer_tick(1'b1, coin(), coin(), 1'b0, IDLE_BEAT);
        while (ph_q != PH_IDLE)
        begin
            if (ph_q == PH_WAIT)
                offer_tick(coin(), $urandom_range(0, 2) == 0, coin(), 1'b0, IDLE_BEAT);
            else
            begin
                if (bit_pos == 0)
                begin
                    case ($urandom_range(0, 5))
                        0: word = '0;
                        1: word = '1;
                        2: word = 16'h8000;
                        default: word = WORD_BITS'($urandom);
                    endcase
                end
                offer_tick(coin(), coin(), word[WORD_BITS - 1 - bit_pos], 1'b0, IDLE_BEAT);
            end
        end
    endtask

    always @(negedge clk)
    begin
        pin_beat_t seen;
        pin_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{convst_n, chip_sel_n, clock_pulse, data_out, busy_res, done_res, ok,
                     result};
            if (due_beats.size() == 0)
                log_mismatch($sformatf("beat %0d arrived with nothing expected", beats_seen));
            else
            begin
                want = due_beats.pop_front();
                check_pin("convst_n", SUM_W'(seen.convst_n), SUM_W'(want.convst_n));
                check_pin("chip_sel_n", SUM_W'(seen.chip_sel_n), SUM_W'(want.chip_sel_n));
                check_pin("clock_pulse", SUM_W'(seen.clock_pulse), SUM_W'(want.clock_pulse));
                check_pin("data_out", SUM_W'(seen.data_out), SUM_W'(want.data_out));
                check_pin("busy_res", SUM_W'(seen.busy), SUM_W'(want.busy));
                check_pin("done_res", SUM_W'(seen.done), SUM_W'(want.done));
                check_pin("ok", SUM_W'(seen.ok), SUM_W'(want.ok));
                check_pin("result", seen.result, want.result);
            end
            beats_seen++;
        end
    end

    initial
    begin
        int pause;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stall_req > 0)
            begin
                pause = stall_req;
                stall_req = 0;
            end
            else
                pause = burst ? 0 : $urandom_range(0, 10);
            if (pause > 0)
            begin
                out_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid) @(negedge clk);
            @(posedge clk);
        end
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int round;
        round = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                repeat (directed_rows[i].reps)
                    offer_tick(directed_rows[i].start, directed_rows[i].eoc,
                               directed_rows[i].dout, directed_rows[i].typed,
                               directed_rows[i].want);
        end

        live_ticks = 0;
        while (live_ticks < 1050)
        begin
            round++;
            case ($urandom_range(0, 9))
                0: write_reg(CFG_SAMPLE_COUNT, 16'd0);
                1: write_reg(CFG_SAMPLE_COUNT, 16'd1);
                8, 9: write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'($urandom_range(5, 12)));
                default: write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'($urandom_range(0, 4)));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(CFG_TIMEOUT_LIMIT, 16'd1);
                1: write_reg(CFG_TIMEOUT_LIMIT, CFG_DATA_W'($urandom_range(2, 6)));
                2: write_reg(CFG_TIMEOUT_LIMIT, 16'hFFFF);
                3: write_reg(CFG_TIMEOUT_LIMIT, CFG_DATA_W'($urandom_range(7, 64)));
                default: write_reg(CFG_TIMEOUT_LIMIT, CFG_DATA_W'($urandom_range(1000, 65535)));
            endcase
            burst = (round % 4 == 2);
            // receiver backs off while the sender keeps pushing
            if (round == 3)
                stall_req = 150;
            repeat ($urandom_range(2, 5)) measure_run();
        end

        // conversion count saturates at 255; a short timeout ends each run early
        burst = 1'b0;
        write_reg(CFG_SAMPLE_COUNT, 16'd255);
        write_reg(CFG_TIMEOUT_LIMIT, 16'd4);
        repeat (4) measure_run();

        if (in_live)
            in_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatches == 0 && due_beats.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
